// ===== rtl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

    localparam int DQ_CAPACITY = 16;
    localparam int DQ_WORD_W   = 32;
    localparam int DQ_OCC_W    = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_action                       action;
        logic signed [DQ_WORD_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        t_status                       status;
        logic signed [DQ_WORD_W-1:0]   popped;
        logic [DQ_OCC_W-1:0]           occupancy;
    } t_out_item;

    // Per-cell command: shift toward the rear, shift toward the front, or load the pushed word.
    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none

// A request's result is registered and offered in the cycle after its transfer.
// Throughput: one request per cycle; the cell row shifts or loads in the same edge.
// The input stalls only while a finished result waits at a stalled output.
// Reset clears the word count and the output valid; the cell contents are not reset
// and hold no meaning until a push writes them.
module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire dq_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output dq_pkg::t_out_item      o_out_item
);
    import dq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    t_out_item                   r_out_item;
    t_out_item                   n_out_item;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        is_push;
    logic                        push_ok;
    logic                        pop_ok;
    logic [IW-1:0]               rear_idx;
    logic signed [DQ_WORD_W-1:0] cell_data [CAPACITY];
    t_cell_ctl                   cell_ctl  [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(CAPACITY));
    assign empty      = (r_count == '0);
    assign is_push    = (i_in_item.action == ACT_PUSH_FRONT) ||
                        (i_in_item.action == ACT_PUSH_REAR);
    assign push_ok    = accept && is_push && !full;
    assign pop_ok     = accept && !is_push && !empty;
    assign rear_idx   = IW'(r_count - CW'(1));

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DQ_WORD_W-1:0] left_data;
        logic signed [DQ_WORD_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = i_in_item.value;
        end else begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_right
            assign right_data = cell_data[i+1];
        end

        // The front word always sits in cell 0; a rear push lands in the first free cell.
        assign cell_ctl[i].shift_r = push_ok && (i_in_item.action == ACT_PUSH_FRONT);
        assign cell_ctl[i].shift_l = pop_ok && (i_in_item.action == ACT_POP_FRONT);
        assign cell_ctl[i].load    = push_ok && (i_in_item.action == ACT_PUSH_REAR) &&
                                     (r_count == CW'(i));

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[i]),
            .i_left  (left_data),
            .i_right (right_data),
            .i_value (i_in_item.value),
            .o_data  (cell_data[i])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_out_valid       = 1'b1;
            n_out_item.status = ST_OK;
            n_out_item.popped = '0;
            if (is_push) begin
                if (full) begin
                    n_out_item.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (empty) begin
                    n_out_item.status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    if (i_in_item.action == ACT_POP_FRONT) begin
                        n_out_item.popped = cell_data[0];
                    end else begin
                        n_out_item.popped = cell_data[rear_idx];
                    end
                end
            end
            n_out_item.occupancy = DQ_OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/dq_cell.sv =====
`default_nettype none

module dq_cell (
    input  wire                                  i_clk,
    input  wire dq_pkg::t_cell_ctl               i_ctl,
    input  wire logic signed [dq_pkg::DQ_WORD_W-1:0] i_left,
    input  wire logic signed [dq_pkg::DQ_WORD_W-1:0] i_right,
    input  wire logic signed [dq_pkg::DQ_WORD_W-1:0] i_value,
    output logic signed [dq_pkg::DQ_WORD_W-1:0]      o_data
);
    import dq_pkg::*;

    logic signed [DQ_WORD_W-1:0] r_data;
    logic signed [DQ_WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_r) begin
            n_data = i_left;
        end else if (i_ctl.shift_l) begin
            n_data = i_right;
        end else if (i_ctl.load) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
